// File: hdl/fdc_pkg.sv
package fdc_pkg;

    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 11;
    localparam int CRC_W       = 16;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 11;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_TUSER_W = 4;

    localparam logic [LEN_W-1:0]  MAX_PAYLOAD = 11'd1024;
    localparam logic [15:0]       FIXED_LEN   = 16'd15;
    localparam logic [CRC_W-1:0]  CRC_INIT    = 16'hFFFF;
    localparam logic [CRC_W-1:0]  CRC_POLY    = 16'hA001;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_HEAD_FIRST   = 3'd0,
        CFG_HEAD_SECOND  = 3'd1,
        CFG_TAIL_FIRST   = 3'd2,
        CFG_TAIL_SECOND  = 3'd3,
        CFG_MAX_DATA_LEN = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_BUSY = 3'd0,
        ST_OK   = 3'd1,
        ST_HEAD = 3'd2,
        ST_LEN  = 3'd3,
        ST_CRC  = 3'd4,
        ST_TAIL = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        PH_HEAD1 = 3'd0,
        PH_HEAD2 = 3'd1,
        PH_LENLO = 3'd2,
        PH_LENHI = 3'd3,
        PH_BODY  = 3'd4
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] head_first;
        logic [BYTE_W-1:0] head_second;
        logic [BYTE_W-1:0] tail_first;
        logic [BYTE_W-1:0] tail_second;
        logic [LEN_W-1:0]  limit;
    } t_cfg;

    typedef struct packed {
        logic [LEN_W-1:0]  frame_length;
        t_status           status;
        logic              frame_end;
        logic              in_frame;
        logic [BYTE_W-1:0] out_byte;
    } t_result;

    // Modbus CRC-16 update for one byte, LSB first
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// File: hdl/fdc_cfg.sv
module fdc_cfg
    import fdc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    logic [BYTE_W-1:0] r_head_first, r_head_second, r_tail_first, r_tail_second;
    logic [LEN_W-1:0]  r_max_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_first  <= '0;
            r_head_second <= '0;
            r_tail_first  <= '0;
            r_tail_second <= '0;
            r_max_len     <= MAX_PAYLOAD;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_HEAD_FIRST:   r_head_first  <= i_cfg_data[BYTE_W-1:0];
                CFG_HEAD_SECOND:  r_head_second <= i_cfg_data[BYTE_W-1:0];
                CFG_TAIL_FIRST:   r_tail_first  <= i_cfg_data[BYTE_W-1:0];
                CFG_TAIL_SECOND:  r_tail_second <= i_cfg_data[BYTE_W-1:0];
                CFG_MAX_DATA_LEN: r_max_len     <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // saturate the payload limit
    assign o_cfg.head_first  = r_head_first;
    assign o_cfg.head_second = r_head_second;
    assign o_cfg.tail_first  = r_tail_first;
    assign o_cfg.tail_second = r_tail_second;
    assign o_cfg.limit       = (r_max_len > MAX_PAYLOAD) ? MAX_PAYLOAD : r_max_len;

endmodule

// File: hdl/fdc_parse.sv
module fdc_parse
    import fdc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [BYTE_W-1:0] i_byte,
    input  t_cfg              i_cfg,
    output t_result           o_result
);

    t_phase            r_phase, n_phase;
    logic [LEN_W-1:0]  r_index, n_index;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [CRC_W-1:0]  r_crc, n_crc;
    logic [BYTE_W-1:0] r_crch, n_crch;

    logic [CRC_W-1:0]  crc_run, crc_new;
    logic              hit_h1, hit_h2, hit_t1, hit_t2, len_ok, crc_ok;
    logic [15:0]       len_rx;
    logic [LEN_W-1:0]  len_m4, len_m3, len_m2;

    assign crc_run = crc_byte(r_crc, i_byte);
    assign crc_new = crc_byte(CRC_INIT, i_byte);
    assign hit_h1  = (i_byte == i_cfg.head_first);
    assign hit_h2  = (i_byte == i_cfg.head_second);
    assign hit_t1  = (i_byte == i_cfg.tail_first);
    assign hit_t2  = (i_byte == i_cfg.tail_second);
    assign len_rx  = {i_byte, r_len[BYTE_W-1:0]};
    assign len_ok  = (len_rx >= FIXED_LEN) &&
                     (len_rx <= FIXED_LEN + {{(16-LEN_W){1'b0}}, i_cfg.limit});
    assign crc_ok  = (r_crch == r_crc[15:8]) && (i_byte == r_crc[7:0]);
    assign len_m4  = r_len - LEN_W'(4);
    assign len_m3  = r_len - LEN_W'(3);
    assign len_m2  = r_len - LEN_W'(2);

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_HEAD1: n_phase = hit_h1 ? PH_HEAD2 : PH_HEAD1;
            PH_HEAD2: n_phase = hit_h2 ? PH_LENLO : (hit_h1 ? PH_HEAD2 : PH_HEAD1);
            PH_LENLO: n_phase = PH_LENHI;
            PH_LENHI: n_phase = len_ok ? PH_BODY : PH_HEAD1;
            PH_BODY: begin
                if (r_index < len_m4 || r_index == len_m4) begin
                    n_phase = PH_BODY;
                end else if (r_index == len_m3) begin
                    n_phase = crc_ok ? PH_BODY : PH_HEAD1;
                end else if (r_index == len_m2) begin
                    n_phase = hit_t1 ? PH_BODY : PH_HEAD1;
                end else begin
                    n_phase = PH_HEAD1;
                end
            end
            default: n_phase = PH_HEAD1;
        endcase
    end

    // datapath and result
    always_comb begin
        n_index  = r_index;
        n_len    = r_len;
        n_crc    = r_crc;
        n_crch   = r_crch;
        o_result.out_byte     = i_byte;
        o_result.in_frame     = 1'b1;
        o_result.frame_end    = 1'b0;
        o_result.status       = ST_BUSY;
        o_result.frame_length = '0;
        unique case (r_phase)
            PH_HEAD1: begin
                if (hit_h1) begin
                    n_index = LEN_W'(1);
                    n_len   = '0;
                    n_crch  = '0;
                    n_crc   = crc_new;
                end else begin
                    o_result.in_frame = 1'b0;
                    o_result.status   = ST_HEAD;
                end
            end
            PH_HEAD2: begin
                if (hit_h2) begin
                    n_crc   = crc_run;
                    n_index = LEN_W'(2);
                end else begin
                    // re-examine the byte as a first head byte
                    o_result.status    = ST_HEAD;
                    o_result.frame_end = 1'b1;
                    n_len  = '0;
                    n_crch = '0;
                    if (hit_h1) begin
                        n_index = LEN_W'(1);
                        n_crc   = crc_new;
                    end else begin
                        o_result.in_frame = 1'b0;
                        n_index = '0;
                        n_crc   = CRC_INIT;
                    end
                end
            end
            PH_LENLO: begin
                n_crc   = crc_run;
                n_len   = {{(LEN_W-BYTE_W){1'b0}}, i_byte};
                n_index = LEN_W'(3);
            end
            PH_LENHI: begin
                if (len_ok) begin
                    n_crc   = crc_run;
                    n_len   = len_rx[LEN_W-1:0];
                    n_index = LEN_W'(4);
                    o_result.frame_length = len_rx[LEN_W-1:0];
                end else begin
                    o_result.status    = ST_LEN;
                    o_result.frame_end = 1'b1;
                    n_index = '0;
                    n_len   = '0;
                    n_crc   = CRC_INIT;
                    n_crch  = '0;
                end
            end
            PH_BODY: begin
                o_result.frame_length = r_len;
                if (r_index < len_m4) begin
                    n_crc   = crc_run;
                    n_index = r_index + LEN_W'(1);
                end else if (r_index == len_m4) begin
                    n_crch  = i_byte;
                    n_index = r_index + LEN_W'(1);
                end else if (r_index == len_m3 && crc_ok) begin
                    n_index = r_index + LEN_W'(1);
                end else if (r_index == len_m2 && hit_t1) begin
                    n_index = r_index + LEN_W'(1);
                end else begin
                    o_result.frame_end = 1'b1;
                    if (r_index == len_m3) begin
                        o_result.status = ST_CRC;
                    end else if (r_index == len_m2) begin
                        o_result.status = ST_TAIL;
                    end else begin
                        o_result.status = hit_t2 ? ST_OK : ST_TAIL;
                    end
                    n_index = '0;
                    n_len   = '0;
                    n_crc   = CRC_INIT;
                    n_crch  = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEAD1;
            r_index <= '0;
            r_len   <= '0;
            r_crc   <= CRC_INIT;
            r_crch  <= '0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_index <= n_index;
            r_len   <= n_len;
            r_crc   <= n_crc;
            r_crch  <= n_crch;
        end
    end

endmodule

// File: hdl/fdc_skid.sv
module fdc_skid
    import fdc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_result i_data,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    logic    r_out_valid, r_skid_valid;
    t_result r_out_data, r_skid_data;
    logic    out_free, take;

    assign o_ready  = !r_skid_valid;
    assign take     = i_valid && !r_skid_valid;
    assign out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= take;
            end
        end else if (take) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_data <= r_skid_valid ? r_skid_data : i_data;
        end else if (take) begin
            r_skid_data <= i_data;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule

// File: hdl/frame_deframer_crc16_check_core.sv
// Channel  | Dir | tdata (LSB up)                         | tuser / tlast
// s_axis   | in  | [7:0] rx_byte                          | -
// m_axis   | out | [7:0] out_byte, [18:8] frame_length,   | tuser [0] in_frame,
//          |     | [23:19] zero                           | [3:1] status; tlast frame_end
// cfg      | in  | i_cfg_we, i_cfg_addr, i_cfg_data       | -
//
// One byte per cycle while s_axis_tready is high; results reach m_axis from a register.
// The parser state updates on every accepted byte; a byte-wide CRC step sets the path.
// A result register plus one skid entry let s_axis take one more byte while m_axis
// stalls; s_axis_tready drops only when the skid entry is full.
// Synchronous active-low reset: parser returns to head hunting, registers to defaults.
module frame_deframer_crc16_check_core
    import fdc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // byte stream in
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] rx_byte
    // echoed bytes with frame status out
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [7:0] out_byte, [18:8] frame_length
    output logic [OUT_TUSER_W-1:0] m_axis_tuser,   // [0] in_frame, [3:1] status
    output logic                   m_axis_tlast,   // frame_end
    // register writes
    input  logic                   i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cfg    cfg;
    t_result res_in, res_out;
    logic    take;

    fdc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // advance the parser only on an accepted word
    assign take = s_axis_tvalid && s_axis_tready;

    fdc_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_byte   (s_axis_tdata[BYTE_W-1:0]),
        .i_cfg    (cfg),
        .o_result (res_in)
    );

    fdc_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (res_in),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (res_out)
    );

    // pack the result word
    assign m_axis_tdata = {{(OUT_TDATA_W-BYTE_W-LEN_W){1'b0}},
                           res_out.frame_length, res_out.out_byte};
    assign m_axis_tuser = {res_out.status, res_out.in_frame};
    assign m_axis_tlast = res_out.frame_end;

endmodule

// File: hdl/fdc_checker.sv
module fdc_checker
    import fdc_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [OUT_TUSER_W-1:0] m_axis_tuser,
    input logic                   m_axis_tlast
);

    // busy words never close a frame
    a_busy_no_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[3:1] == ST_BUSY |-> !m_axis_tlast)
        else $error("busy word marked as frame end");

    // a good frame ends inside the frame with a legal length
    a_ok_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[3:1] == ST_OK |->
            m_axis_tlast && m_axis_tuser[0] && m_axis_tdata[18:8] >= 11'd15)
        else $error("frame ok word inconsistent");

    // input stalls only when the output is holding a word
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !$past(m_axis_tready))
        else $error("input stalled without output backpressure");

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled output word changed");

endmodule

bind frame_deframer_crc16_check_core fdc_checker u_fdc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
